// ===== design/rct_pkg.sv =====
// Shared codes, widths and handshake structs for the return completion tracker.
package rct_pkg;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int ENT_W   = KEY_W + DATA_W;
  localparam int MODE_W  = 3;
  localparam int ST_W    = 3;
  localparam int SEL_W   = 4;

  localparam logic [MODE_W-1:0] MODE_REG_WAIT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REG_READ = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RSP_WAIT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RSP_READ = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QRY_WAIT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QRY_READ = 3'd5;

  localparam logic [ST_W-1:0] ST_OK   = 3'd0;
  localparam logic [ST_W-1:0] ST_NONE = 3'd1;
  localparam logic [ST_W-1:0] ST_KIND = 3'd2;
  localparam logic [ST_W-1:0] ST_KEY  = 3'd3;
  localparam logic [ST_W-1:0] ST_DUP  = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL = 3'd5;

  localparam logic KIND_WAIT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef struct packed {
    logic              go;
    logic              op;
    logic              rm;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } lst_req_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [DATA_W-1:0] data;
  } lst_rsp_t;

endpackage

// ===== design/return_completion_tracker_core.sv =====
// Top level: expected-return queue, response checking and query sequencing.
//
//  channel | dir | ports                         | carries
//  in_     | in  | tvalid tready tdata tuser     | one request (mode in tuser)
//  out_    | out | tvalid tready tdata           | done_res, read_data, status
//
// One item at a time. Registration and query walk the completion list one
// entry a cycle, with a shift pass when a query removes an entry that is
// not the last one.
// Reset empties all three stores through their counts; no clearing pass.
// A waiting result holds the sequencer until out_tready.
module return_completion_tracker_core import rct_pkg::*; #(
  parameter int EXPECT_DEPTH = 16,
  parameter int WAIT_DEPTH   = 16,
  parameter int READ_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] return_requested, [32:1] key, [36:33] dword_select,
  // [68:37] payload, [69] peek
  input  logic [71:0] in_tdata,
  // [2:0] mode
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] done_res, [32:1] read_data, [35:33] status
  output logic [39:0] out_tdata
);

  localparam int EAW = (EXPECT_DEPTH > 1) ? $clog2(EXPECT_DEPTH) : 1;
  localparam int ECW = $clog2(EXPECT_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_REG   = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_QRY   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        st_r, st_nxt;
  logic [MODE_W-1:0] mode_r;
  logic              req_r;
  logic [KEY_W-1:0]  key_r;
  logic [SEL_W-1:0]  sel_r;
  logic [DATA_W-1:0] pay_r;
  logic              peek_r;

  logic [EAW-1:0]    ehead_r, ehead_nxt, etail_r, etail_nxt;
  logic [ECW-1:0]    ecnt_r, ecnt_nxt;
  logic [KEY_W:0]    emem [EXPECT_DEPTH];
  logic [KEY_W:0]    erd_q;
  logic              ewe;

  logic              res_done_r, res_done_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;

  logic              out_tvalid_r;
  logic [39:0]       out_tdata_r;

  lst_req_t          wreq, rreq, lreq;
  lst_rsp_t          wrsp, rrsp, lrsp;
  logic              wfull, rfull, lfull;
  logic              kind;
  logic [KEY_W-1:0]  addr;
  logic [KEY_W-1:0]  rkey;
  logic              efull;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign kind  = mode_r[0];
  assign addr  = key_r + {{(KEY_W-SEL_W-2){1'b0}}, sel_r, 2'b00};
  assign rkey  = (kind == KIND_WAIT) ? pay_r : key_r;
  assign efull = (ecnt_r == ECW'(EXPECT_DEPTH));
  assign lrsp  = (kind == KIND_WAIT) ? wrsp : rrsp;
  assign lfull = (kind == KIND_WAIT) ? wfull : rfull;

  always_ff @(posedge clk) begin
    if (ewe) begin
      emem[etail_r] <= {kind, (kind == KIND_WAIT) ? key_r : addr};
    end
    erd_q <= emem[ehead_r];
  end

  rct_list #(.DEPTH(WAIT_DEPTH)) u_wait (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (wreq),
    .rsp  (wrsp),
    .full (wfull)
  );

  rct_list #(.DEPTH(READ_DEPTH)) u_read (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (rreq),
    .rsp  (rrsp),
    .full (rfull)
  );

  always_comb begin
    st_nxt       = st_r;
    ehead_nxt    = ehead_r;
    etail_nxt    = etail_r;
    ecnt_nxt     = ecnt_r;
    ewe          = 1'b0;
    res_done_nxt = res_done_r;
    res_data_nxt = res_data_r;
    res_st_nxt   = res_st_r;
    lreq         = '0;
    lreq.key     = (mode_r == MODE_REG_READ) ? addr : key_r;
    lreq.data    = pay_r;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_done_nxt = 1'b0;
        res_data_nxt = '0;
        res_st_nxt   = ST_OK;
        st_nxt       = S_FIN;
        case (mode_r)
          MODE_REG_WAIT, MODE_REG_READ: begin
            if (mode_r == MODE_REG_READ || req_r) begin
              if (efull) begin
                res_st_nxt = ST_FULL;
              end else begin
                lreq.go = 1'b1;
                lreq.op = OP_FIND;
                st_nxt  = S_REG;
              end
            end
          end
          MODE_RSP_WAIT, MODE_RSP_READ: begin
            if (ecnt_r == '0) begin
              res_st_nxt = ST_NONE;
            end else if (lfull) begin
              res_st_nxt = ST_FULL;
            end else begin
              st_nxt = S_FRONT;
            end
          end
          MODE_QRY_WAIT, MODE_QRY_READ: begin
            lreq.go = 1'b1;
            lreq.op = OP_FIND;
            lreq.rm = !peek_r;
            st_nxt  = S_QRY;
          end
          default: begin
            st_nxt = S_FIN;
          end
        endcase
      end
      S_REG: begin
        if (lrsp.done) begin
          ewe          = 1'b1;
          etail_nxt    = (etail_r == EAW'(EXPECT_DEPTH - 1)) ? '0 : etail_r + EAW'(1);
          ecnt_nxt     = ecnt_r + ECW'(1);
          res_done_nxt = 1'b1;
          res_st_nxt   = lrsp.hit ? ST_DUP : ST_OK;
          st_nxt       = S_FIN;
        end
      end
      S_FRONT: begin
        if (erd_q[KEY_W] != kind) begin
          res_st_nxt = ST_KIND;
        end else if (erd_q[KEY_W-1:0] != rkey) begin
          res_st_nxt = ST_KEY;
        end
        ehead_nxt    = (ehead_r == EAW'(EXPECT_DEPTH - 1)) ? '0 : ehead_r + EAW'(1);
        ecnt_nxt     = ecnt_r - ECW'(1);
        lreq.go      = 1'b1;
        lreq.op      = OP_APPEND;
        lreq.key     = rkey;
        res_done_nxt = 1'b1;
        st_nxt       = S_FIN;
      end
      S_QRY: begin
        if (lrsp.done) begin
          res_done_nxt = lrsp.hit;
          res_data_nxt = (kind == KIND_READ && lrsp.hit) ? lrsp.data : '0;
          st_nxt       = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    wreq    = lreq;
    rreq    = lreq;
    wreq.go = lreq.go && (kind == KIND_WAIT);
    rreq.go = lreq.go && (kind == KIND_READ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      ehead_r      <= '0;
      etail_r      <= '0;
      ecnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ehead_r <= ehead_nxt;
      etail_r <= etail_nxt;
      ecnt_r  <= ecnt_nxt;
      if (st_r == S_FIN && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_done_r <= res_done_nxt;
    res_data_r <= res_data_nxt;
    res_st_r   <= res_st_nxt;
    if (in_tvalid && in_tready) begin
      mode_r <= in_tuser;
      req_r  <= in_tdata[0];
      key_r  <= in_tdata[32:1];
      sel_r  <= in_tdata[36:33];
      pay_r  <= in_tdata[68:37];
      peek_r <= in_tdata[69];
    end
    if (st_r == S_FIN && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {4'b0000, res_st_r, res_data_r, res_done_r};
    end
  end

endmodule

// ===== design/rct_list.sv =====
// Completion list: ordered store with linear search, append and delete-by-shift.
module rct_list import rct_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  lst_req_t req,
  output lst_rsp_t rsp,
  output logic     full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [1:0] L_IDLE  = 2'd0;
  localparam logic [1:0] L_SCAN  = 2'd1;
  localparam logic [1:0] L_SHIFT = 2'd2;

  logic [1:0]        st_r, st_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     cmp_r, cmp_nxt;
  logic [AW-1:0]     wr_r, wr_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              rm_r, rm_nxt;
  logic [DATA_W-1:0] dat_r, dat_nxt;
  lst_rsp_t          rsp_r, rsp_nxt;

  logic [ENT_W-1:0]  mem [DEPTH];
  logic [ENT_W-1:0]  rd_q;
  logic              we;
  logic [AW-1:0]     wa, ra;
  logic [ENT_W-1:0]  wd;
  logic              more;

  assign full = (cnt_r == CW'(DEPTH));
  assign rsp  = rsp_r;
  assign more = (iss_r < cnt_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    iss_nxt  = iss_r;
    pend_nxt = pend_r;
    cmp_nxt  = cmp_r;
    wr_nxt   = wr_r;
    key_nxt  = key_r;
    rm_nxt   = rm_r;
    dat_nxt  = dat_r;
    rsp_nxt  = '0;
    we       = 1'b0;
    wa       = cnt_r[AW-1:0];
    wd       = {req.data, req.key};
    ra       = iss_r[AW-1:0];
    case (st_r)
      L_IDLE: begin
        if (req.go) begin
          if (req.op == OP_APPEND) begin
            if (!full) begin
              we      = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end else begin
            key_nxt  = req.key;
            rm_nxt   = req.rm;
            iss_nxt  = '0;
            pend_nxt = 1'b0;
            st_nxt   = L_SCAN;
          end
        end
      end
      L_SCAN: begin
        // one read issued per cycle, compared the cycle after
        if (more) begin
          iss_nxt  = iss_r + CW'(1);
          pend_nxt = 1'b1;
          cmp_nxt  = iss_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && rd_q[KEY_W-1:0] == key_r) begin
          dat_nxt  = rd_q[ENT_W-1:KEY_W];
          pend_nxt = 1'b0;
          if (rm_r && (SW'(cmp_r) + SW'(1) < SW'(cnt_r))) begin
            wr_nxt = cmp_r;
            ra     = AW'(SW'(cmp_r) + SW'(1));
            st_nxt = L_SHIFT;
          end else begin
            if (rm_r) begin
              cnt_nxt = cnt_r - CW'(1);
            end
            rsp_nxt.done = 1'b1;
            rsp_nxt.hit  = 1'b1;
            rsp_nxt.data = rd_q[ENT_W-1:KEY_W];
            st_nxt       = L_IDLE;
          end
        end else if (!pend_r && !more) begin
          rsp_nxt.done = 1'b1;
          st_nxt       = L_IDLE;
        end
      end
      L_SHIFT: begin
        // entry wr+1 arrives, lands at wr; fetch wr+2 meanwhile
        we     = 1'b1;
        wa     = wr_r;
        wd     = rd_q;
        wr_nxt = AW'(SW'(wr_r) + SW'(1));
        if (SW'(wr_r) + SW'(2) < SW'(cnt_r)) begin
          ra = AW'(SW'(wr_r) + SW'(2));
        end else begin
          cnt_nxt      = cnt_r - CW'(1);
          rsp_nxt.done = 1'b1;
          rsp_nxt.hit  = 1'b1;
          rsp_nxt.data = dat_r;
          st_nxt       = L_IDLE;
        end
      end
      default: begin
        st_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      cnt_r  <= '0;
      iss_r  <= '0;
      pend_r <= 1'b0;
      rsp_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      iss_r  <= iss_nxt;
      pend_r <= pend_nxt;
      rsp_r  <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_r <= cmp_nxt;
    wr_r  <= wr_nxt;
    key_r <= key_nxt;
    rm_r  <= rm_nxt;
    dat_r <= dat_nxt;
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench for the return completion tracker: directed and random traffic vs a predictor.
module tb_top;
  import rct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int IDLE_LIMIT = 20000;

  // laid out as out_tdata: done_res in the lowest bit
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] rdata;
    logic        done;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  return_completion_tracker_core i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic        pend_kind[$];
  logic [31:0] pend_key[$];
  logic [31:0] waits_done[$];
  logic [31:0] reads_addr[$];
  logic [31:0] reads_data[$];
  outcome_t    outcomes_due[$];

  int  errors = 0;
  int  sent = 0;
  int  got = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  int  n_status[6] = '{default: 0};

  function automatic int find_key(ref logic [31:0] lst[$], input logic [31:0] k);
    foreach (lst[i]) if (lst[i] == k) return i;
    return -1;
  endfunction

  function automatic outcome_t track_step(logic [2:0] mode, logic req, logic [31:0] key,
                                          logic [3:0] sel, logic [31:0] pay, logic pk);
    outcome_t   r;
    logic [31:0] addr;
    logic        kind;
    logic [31:0] rkey;
    bit          dup;
    int          idx;
    r = '0;
    case (mode)
      MODE_REG_WAIT, MODE_REG_READ: begin
        if (mode == MODE_REG_WAIT && !req) return r;
        kind = (mode == MODE_REG_READ) ? KIND_READ : KIND_WAIT;
        addr = (mode == MODE_REG_READ) ? key + {26'd0, sel, 2'b00} : key;
        dup = (kind == KIND_READ) ? find_key(reads_addr, addr) >= 0
                                  : find_key(waits_done, addr) >= 0;
        if (pend_key.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pend_kind = {pend_kind, kind};
          pend_key = {pend_key, addr};
          r.done = 1'b1;
          r.status = dup ? ST_DUP : ST_OK;
        end
      end
      MODE_RSP_WAIT, MODE_RSP_READ: begin
        kind = (mode == MODE_RSP_READ) ? KIND_READ : KIND_WAIT;
        rkey = (mode == MODE_RSP_READ) ? key : pay;
        if (pend_key.size() == 0) r.status = ST_NONE;
        else if ((kind == KIND_WAIT && waits_done.size() >= DEPTH) ||
                 (kind == KIND_READ && reads_addr.size() >= DEPTH)) r.status = ST_FULL;
        else begin
          if (pend_kind[0] != kind) r.status = ST_KIND;
          else if (pend_key[0] != rkey) r.status = ST_KEY;
          void'(pend_kind.pop_front());
          void'(pend_key.pop_front());
          if (kind == KIND_WAIT) waits_done = {waits_done, pay};
          else begin
            reads_addr = {reads_addr, key};
            reads_data = {reads_data, pay};
          end
          r.done = 1'b1;
        end
      end
      MODE_QRY_WAIT: begin
        idx = find_key(waits_done, key);
        if (idx >= 0) begin
          r.done = 1'b1;
          if (!pk) waits_done.delete(idx);
        end
      end
      MODE_QRY_READ: begin
        idx = find_key(reads_addr, key);
        if (idx >= 0) begin
          r.done = 1'b1;
          r.rdata = reads_data[idx];
          if (!pk) begin
            reads_addr.delete(idx);
            reads_data.delete(idx);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid drops only when a gap follows, so back to back items see one drive per edge
  task automatic send_request(logic [2:0] mode, logic req, logic [31:0] key,
                              logic [3:0] sel, logic [31:0] pay, logic pk);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, pk, pay, sel, key, req};
    outcomes_due = {outcomes_due, track_step(mode, req, key, sel, pay, pk)};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // receiver readiness, with random stalls and an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 1'b0;
      else out_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  // result checking
  always @(posedge clk) begin
    outcome_t exp_r, act;
    if (rst_n && out_tvalid && out_tready) begin
      act = out_tdata[35:0];
      got++;
      if (outcomes_due.size() == 0) begin
        $error("result with nothing expected: %h", act);
        errors++;
      end else begin
        exp_r = outcomes_due.pop_front();
        if (act.status <= ST_FULL) n_status[act.status]++;
        if (act.done !== exp_r.done) begin
          $error("done_res expected %0d actual %0d", exp_r.done, act.done);
          errors++;
        end
        if (act.rdata !== exp_r.rdata) begin
          $error("read_data expected %h actual %h", exp_r.rdata, act.rdata);
          errors++;
        end
        if (act.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, act.status);
          errors++;
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  task automatic test_edges();
    // empty queue responses, misses, unused modes, a wait registration with no return requested
    send_request(MODE_RSP_WAIT, 1'b0, 32'h0, 4'h0, 32'h0, 1'b0);
    send_request(MODE_RSP_READ, 1'b1, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1'b1);
    send_request(MODE_QRY_WAIT, 1'b0, 32'h1234, 4'h0, 32'h0, 1'b0);
    send_request(MODE_QRY_READ, 1'b0, 32'h1234, 4'h0, 32'h0, 1'b1);
    send_request(3'd6, 1'b1, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1'b1);
    send_request(3'd7, 1'b0, 32'h0, 4'h0, 32'h0, 1'b0);
    send_request(MODE_REG_WAIT, 1'b0, 32'h55, 4'h0, 32'h0, 1'b0);
  endtask

  task automatic test_flow();
    // good pair, key wrap on read address, kind and key mismatch, duplicates, peek
    send_request(MODE_REG_WAIT, 1'b1, 32'hFFFF_FFFF, 4'h0, 32'h0, 1'b0);
    send_request(MODE_REG_READ, 1'b0, 32'hFFFF_FFF0, 4'hF, 32'h0, 1'b0);
    send_request(MODE_RSP_WAIT, 1'b0, 32'h0, 4'h0, 32'hFFFF_FFFF, 1'b0);
    send_request(MODE_RSP_READ, 1'b0, 32'h0000_002C, 4'h0, 32'hDEAD_BEEF, 1'b0);
    send_request(MODE_REG_WAIT, 1'b1, 32'hFFFF_FFFF, 4'h0, 32'h0, 1'b0);
    send_request(MODE_REG_READ, 1'b0, 32'h0000_0020, 4'h3, 32'h0, 1'b0);
    send_request(MODE_RSP_READ, 1'b0, 32'h0000_0040, 4'h0, 32'h1, 1'b0);
    send_request(MODE_RSP_READ, 1'b0, 32'h0000_0050, 4'h0, 32'h2, 1'b0);
    send_request(MODE_QRY_READ, 1'b0, 32'h0000_002C, 4'h0, 32'h0, 1'b1);
    send_request(MODE_QRY_READ, 1'b0, 32'h0000_002C, 4'h0, 32'h0, 1'b0);
    send_request(MODE_QRY_WAIT, 1'b0, 32'hFFFF_FFFF, 4'h0, 32'h0, 1'b0);
    send_request(MODE_QRY_READ, 1'b0, 32'h0000_0040, 4'h0, 32'h0, 1'b0);
    send_request(MODE_QRY_READ, 1'b0, 32'h0000_0050, 4'h0, 32'h0, 1'b0);
  endtask

  task automatic test_full();
    // overfill the pending queue with the receiver held off, then drain
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(MODE_REG_WAIT, 1'b1, 32'(i), 4'h0, 32'h0, 1'b0);
    for (int i = 0; i < DEPTH + 1; i++)
      send_request(MODE_RSP_WAIT, 1'b0, 32'h0, 4'h0, 32'(i), 1'b0);
    // done list now full: a further response is refused
    send_request(MODE_REG_WAIT, 1'b1, 32'h3, 4'h0, 32'h0, 1'b0);
    send_request(MODE_RSP_WAIT, 1'b0, 32'h0, 4'h0, 32'h3, 1'b0);
    for (int i = 0; i < DEPTH; i++)
      send_request(MODE_QRY_WAIT, 1'b0, 32'(i), 4'h0, 32'h0, 1'b0);
    send_request(MODE_RSP_WAIT, 1'b0, 32'h0, 4'h0, 32'h3, 1'b0);
    send_request(MODE_QRY_WAIT, 1'b0, 32'h3, 4'h0, 32'h0, 1'b0);
  endtask

  task automatic test_random(int n);
    logic [31:0] pool[8];
    logic [31:0] k;
    logic [3:0]  s;
    int          c;
    foreach (pool[i]) pool[i] = rnd32();
    while (n > 0) begin
      c = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? rnd32() : pool[$urandom_range(0, 7)];
      s = 4'($urandom_range(0, 15));
      if (c < 5) begin
        // noise, including unused modes and random fields
        send_request(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), rnd32(), s,
                     rnd32(), 1'($urandom_range(0, 1)));
      end else if (c < 45) begin
        // well-formed registration followed by its response, sometimes corrupted
        if ($urandom_range(0, 1)) begin
          send_request(MODE_REG_WAIT, ($urandom_range(0, 9) != 0), k, s, rnd32(), 1'b0);
          send_request(($urandom_range(0, 9) == 0) ? MODE_RSP_READ : MODE_RSP_WAIT,
                       1'($urandom_range(0, 1)), rnd32(), s,
                       ($urandom_range(0, 7) == 0) ? rnd32() : k, 1'b0);
        end else begin
          send_request(MODE_REG_READ, 1'($urandom_range(0, 1)), k, s, rnd32(), 1'b0);
          send_request(($urandom_range(0, 9) == 0) ? MODE_RSP_WAIT : MODE_RSP_READ,
                       1'b0, ($urandom_range(0, 7) == 0) ? rnd32() : k + {26'd0, s, 2'b00},
                       s, rnd32(), 1'b0);
        end
        n--;
      end else if (c < 60) begin
        send_request(MODE_REG_WAIT + 3'($urandom_range(0, 1)), 1'b1, k, s, rnd32(), 1'b0);
      end else if (c < 72) begin
        send_request(MODE_RSP_WAIT + 3'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     k + {26'd0, s, 2'b00}, s, k, 1'($urandom_range(0, 1)));
      end else begin
        send_request(MODE_QRY_WAIT + 3'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 1)) ? k : k + {26'd0, s, 2'b00}, s, rnd32(),
                     ($urandom_range(0, 3) == 0));
      end
      n--;
    end
  endtask

  initial begin
    int guard;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_flow();
    test_full();
    test_random(375);
    in_tvalid <= 1'b0;
    guard = 0;
    while (outcomes_due.size() != 0 && guard < IDLE_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    $display("run: %0d requests, %0d results", sent, got);
    $display("status ok/none/kind/key/dup/full = %0d/%0d/%0d/%0d/%0d/%0d",
             n_status[0], n_status[1], n_status[2], n_status[3], n_status[4],
             n_status[5]);
    if (outcomes_due.size() != 0) begin
      $error("%0d results never arrived", outcomes_due.size());
      errors++;
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== files.f =====
design/rct_pkg.sv
design/rct_list.sv
design/return_completion_tracker_core.sv
test/tb_top.sv
